FILE: design/triangle_overlap_2d_assert.svh
// Assertion macros for the triangle overlap block.
// Used by the top level; no other dependencies.
`ifndef TRIANGLE_OVERLAP_2D_ASSERT_SVH
`define TRIANGLE_OVERLAP_2D_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TOV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TOV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tov_pkg.sv
// Shared constants and types for the triangle overlap pipeline.
// No dependencies.
`default_nettype none

package tov_pkg;

  // Default coordinate width.
  localparam int unsigned COORD_BITS_DEF = 24;

  // Nine orientation signs per direction, two directions.
  localparam int unsigned NUM_ORIENT = 18;

  // Codes for which test decided the result.
  localparam logic [1:0] DEC_NONE   = 2'd0;
  localparam logic [1:0] DEC_FIRST  = 2'd1;
  localparam logic [1:0] DEC_SECOND = 2'd2;
  localparam logic [1:0] DEC_CROSS  = 2'd3;

  // Sign of one determinant: both flags low means zero.
  typedef struct packed {
    logic pos;
    logic neg;
  } sign_t;

endpackage

`default_nettype wire

FILE: design/triangle_overlap_2d.sv
// Top level of the 2D triangle overlap pipeline.
// Depends on tov_pkg, tov_diff, tov_mul, tov_sign, tov_decide and the assert header.
`default_nettype none
`include "triangle_overlap_2d_assert.svh"

// Decides whether two triangles with signed COORD_BITS coordinates overlap,
// using 18 exact orientation signs, and reports which test decided. The
// pipeline has four register stages (differences, products, sign compare,
// decision), and an input transfer passes through them in that order; a new
// pair is taken every cycle while the output is not stalled. Each stage holds
// its item while the next one is full and cannot drain, so a stall at the
// output backs up without losing anything. The product stage, 36 signed
// multipliers of COORD_BITS+1 bits each, sets the clock period.
module triangle_overlap_2d #(
  parameter int unsigned COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] first_v0_x_i,
  input  logic signed [COORD_BITS-1:0] first_v0_y_i,
  input  logic signed [COORD_BITS-1:0] first_v1_x_i,
  input  logic signed [COORD_BITS-1:0] first_v1_y_i,
  input  logic signed [COORD_BITS-1:0] first_v2_x_i,
  input  logic signed [COORD_BITS-1:0] first_v2_y_i,
  input  logic signed [COORD_BITS-1:0] second_v0_x_i,
  input  logic signed [COORD_BITS-1:0] second_v0_y_i,
  input  logic signed [COORD_BITS-1:0] second_v1_x_i,
  input  logic signed [COORD_BITS-1:0] second_v1_y_i,
  input  logic signed [COORD_BITS-1:0] second_v2_x_i,
  input  logic signed [COORD_BITS-1:0] second_v2_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         overlaps_o,
  output logic [1:0]                   decided_by_o
);
  import tov_pkg::*;

  localparam int unsigned DiffBits = COORD_BITS + 1;
  localparam int unsigned ProdBits = 2 * DiffBits;

  logic signed [COORD_BITS-1:0] x_in [2][3];
  logic signed [COORD_BITS-1:0] y_in [2][3];

  logic                       d_valid;
  logic                       d_ready;
  logic signed [DiffBits-1:0] ex [NUM_ORIENT];
  logic signed [DiffBits-1:0] ey [NUM_ORIENT];
  logic signed [DiffBits-1:0] px [NUM_ORIENT];
  logic signed [DiffBits-1:0] py [NUM_ORIENT];

  logic                       m_valid;
  logic                       m_ready;
  logic signed [ProdBits-1:0] l_prod [NUM_ORIENT];
  logic signed [ProdBits-1:0] r_prod [NUM_ORIENT];

  logic                       s_valid;
  logic                       s_ready;
  sign_t                      sign [NUM_ORIENT];

  // Gather vertices: index 0 is the first triangle, 1 the second.
  assign x_in[0][0] = first_v0_x_i;
  assign y_in[0][0] = first_v0_y_i;
  assign x_in[0][1] = first_v1_x_i;
  assign y_in[0][1] = first_v1_y_i;
  assign x_in[0][2] = first_v2_x_i;
  assign y_in[0][2] = first_v2_y_i;
  assign x_in[1][0] = second_v0_x_i;
  assign y_in[1][0] = second_v0_y_i;
  assign x_in[1][1] = second_v1_x_i;
  assign y_in[1][1] = second_v1_y_i;
  assign x_in[1][2] = second_v2_x_i;
  assign y_in[1][2] = second_v2_y_i;

  tov_diff #(
    .COORD_BITS(COORD_BITS)
  ) u_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_i),
    .ready_o(in_ready_o),
    .x_i    (x_in),
    .y_i    (y_in),
    .valid_o(d_valid),
    .ready_i(d_ready),
    .ex_o   (ex),
    .ey_o   (ey),
    .px_o   (px),
    .py_o   (py)
  );

  tov_mul #(
    .COORD_BITS(COORD_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(d_valid),
    .ready_o(d_ready),
    .ex_i   (ex),
    .ey_i   (ey),
    .px_i   (px),
    .py_i   (py),
    .valid_o(m_valid),
    .ready_i(m_ready),
    .l_o    (l_prod),
    .r_o    (r_prod)
  );

  tov_sign #(
    .COORD_BITS(COORD_BITS)
  ) u_sign (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(m_valid),
    .ready_o(m_ready),
    .l_i    (l_prod),
    .r_i    (r_prod),
    .valid_o(s_valid),
    .ready_i(s_ready),
    .sign_o (sign)
  );

  tov_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_valid),
    .ready_o     (s_ready),
    .sign_i      (sign),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .overlaps_o  (overlaps_o),
    .decided_by_o(decided_by_o)
  );

  // Input back-pressure can only come from a stalled output.
  `TOV_ASSERT_IMP(a_stall_from_out, clk_i, rst_ni, !in_ready_o, !out_ready_i, "input stalled while output ready")
  // A difference transfer must land in the product stage.
  `TOV_ASSERT_NEXT(a_diff_advance, clk_i, rst_ni, d_valid && d_ready, m_valid, "item lost after difference stage")
  // A transfer into the decision stage must show at the output.
  `TOV_ASSERT_NEXT(a_sign_advance, clk_i, rst_ni, s_valid && s_ready, out_valid_o, "item lost after sign stage")
  // The flag agrees with the deciding test.
  `TOV_ASSERT_IMP(a_flag_code, clk_i, rst_ni, out_valid_o, overlaps_o == (decided_by_o != DEC_NONE), "flag and code disagree")

endmodule

`default_nettype wire

FILE: design/tov_diff.sv
// Stage 1: coordinate differences for all 18 orientation lanes.
// Depends on tov_pkg.
`default_nettype none

module tov_diff #(
  parameter int unsigned COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [COORD_BITS-1:0] x_i [2][3],
  input  logic signed [COORD_BITS-1:0] y_i [2][3],
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [COORD_BITS:0] ex_o [tov_pkg::NUM_ORIENT],
  output logic signed [COORD_BITS:0] ey_o [tov_pkg::NUM_ORIENT],
  output logic signed [COORD_BITS:0] px_o [tov_pkg::NUM_ORIENT],
  output logic signed [COORD_BITS:0] py_o [tov_pkg::NUM_ORIENT]
);
  import tov_pkg::*;

  localparam int unsigned DiffBits = COORD_BITS + 1;

  logic                      valid_q;
  logic                      load;
  logic signed [DiffBits-1:0] ex_d [NUM_ORIENT];
  logic signed [DiffBits-1:0] ey_d [NUM_ORIENT];
  logic signed [DiffBits-1:0] px_d [NUM_ORIENT];
  logic signed [DiffBits-1:0] py_d [NUM_ORIENT];
  logic signed [DiffBits-1:0] ex_q [NUM_ORIENT];
  logic signed [DiffBits-1:0] ey_q [NUM_ORIENT];
  logic signed [DiffBits-1:0] px_q [NUM_ORIENT];
  logic signed [DiffBits-1:0] py_q [NUM_ORIENT];

  // Advance when the register is empty or drains this cycle.
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Lane t*9+i*3+k: edge i of one triangle against vertex k of the other.
  // Direction 0 tests first-triangle vertices against second-triangle edges.
  for (genvar t = 0; t < 2; t++) begin : g_dir
    for (genvar i = 0; i < 3; i++) begin : g_edge
      for (genvar k = 0; k < 3; k++) begin : g_vert
        localparam int Lane    = t * 9 + i * 3 + k;
        localparam int EdgeEnd = (i + 1) % 3;
        localparam int TriSel  = 1 - t;
        assign ex_d[Lane] = DiffBits'(x_i[TriSel][EdgeEnd]) - DiffBits'(x_i[TriSel][i]);
        assign ey_d[Lane] = DiffBits'(y_i[TriSel][EdgeEnd]) - DiffBits'(y_i[TriSel][i]);
        assign px_d[Lane] = DiffBits'(x_i[t][k]) - DiffBits'(x_i[TriSel][i]);
        assign py_d[Lane] = DiffBits'(y_i[t][k]) - DiffBits'(y_i[TriSel][i]);
      end
    end
  end

  // Track stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture differences on a transfer.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ex_q <= ex_d;
      ey_q <= ey_d;
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  assign valid_o = valid_q;
  assign ex_o    = ex_q;
  assign ey_o    = ey_q;
  assign px_o    = px_q;
  assign py_o    = py_q;

endmodule

`default_nettype wire

FILE: design/tov_mul.sv
// Stage 2: the two cross products of every orientation lane.
// Depends on tov_pkg.
`default_nettype none

module tov_mul #(
  parameter int unsigned COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [COORD_BITS:0]       ex_i [tov_pkg::NUM_ORIENT],
  input  logic signed [COORD_BITS:0]       ey_i [tov_pkg::NUM_ORIENT],
  input  logic signed [COORD_BITS:0]       px_i [tov_pkg::NUM_ORIENT],
  input  logic signed [COORD_BITS:0]       py_i [tov_pkg::NUM_ORIENT],
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [2*COORD_BITS+1:0]   l_o [tov_pkg::NUM_ORIENT],
  output logic signed [2*COORD_BITS+1:0]   r_o [tov_pkg::NUM_ORIENT]
);
  import tov_pkg::*;

  localparam int unsigned ProdBits = 2 * (COORD_BITS + 1);

  logic                       valid_q;
  logic                       load;
  logic signed [ProdBits-1:0] l_d [NUM_ORIENT];
  logic signed [ProdBits-1:0] r_d [NUM_ORIENT];
  logic signed [ProdBits-1:0] l_q [NUM_ORIENT];
  logic signed [ProdBits-1:0] r_q [NUM_ORIENT];

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Full-width products, one pair of multipliers per lane.
  for (genvar n = 0; n < NUM_ORIENT; n++) begin : g_lane
    assign l_d[n] = ProdBits'(ex_i[n]) * ProdBits'(py_i[n]);
    assign r_d[n] = ProdBits'(ey_i[n]) * ProdBits'(px_i[n]);
  end

  // Track stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture products on a transfer.
  always_ff @(posedge clk_i) begin
    if (load) begin
      l_q <= l_d;
      r_q <= r_d;
    end
  end

  assign valid_o = valid_q;
  assign l_o     = l_q;
  assign r_o     = r_q;

endmodule

`default_nettype wire

FILE: design/tov_sign.sv
// Stage 3: compare the product pairs into orientation signs.
// Depends on tov_pkg.
`default_nettype none

module tov_sign #(
  parameter int unsigned COORD_BITS = tov_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [2*COORD_BITS+1:0] l_i [tov_pkg::NUM_ORIENT],
  input  logic signed [2*COORD_BITS+1:0] r_i [tov_pkg::NUM_ORIENT],
  output logic                           valid_o,
  input  logic                           ready_i,
  output tov_pkg::sign_t                 sign_o [tov_pkg::NUM_ORIENT]
);
  import tov_pkg::*;

  logic  valid_q;
  logic  load;
  sign_t sign_d [NUM_ORIENT];
  sign_t sign_q [NUM_ORIENT];

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Exact sign of l - r without forming the difference.
  for (genvar n = 0; n < NUM_ORIENT; n++) begin : g_lane
    assign sign_d[n].pos = l_i[n] > r_i[n];
    assign sign_d[n].neg = l_i[n] < r_i[n];
  end

  // Track stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Capture signs on a transfer.
  always_ff @(posedge clk_i) begin
    if (load) begin
      sign_q <= sign_d;
    end
  end

  assign valid_o = valid_q;
  assign sign_o  = sign_q;

endmodule

`default_nettype wire

FILE: design/tov_decide.sv
// Stage 4: combine the 18 signs into the overlap flag and deciding test.
// Depends on tov_pkg.
`default_nettype none

module tov_decide (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tov_pkg::sign_t sign_i [tov_pkg::NUM_ORIENT],
  output logic           valid_o,
  input  logic           ready_i,
  output logic           overlaps_o,
  output logic [1:0]     decided_by_o
);
  import tov_pkg::*;

  logic                  valid_q;
  logic                  load;
  logic [NUM_ORIENT-1:0] pos_v;
  logic [NUM_ORIENT-1:0] neg_v;
  logic [1:0][2:0]       vert_in;
  logic [1:0]            contain;
  logic [8:0]            cross_v;
  logic [1:0]            code_d;
  logic [1:0]            code_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // Flatten the signs into flag vectors.
  for (genvar n = 0; n < NUM_ORIENT; n++) begin : g_flat
    assign pos_v[n] = sign_i[n].pos;
    assign neg_v[n] = sign_i[n].neg;
  end

  // Vertex strictly inside: same nonzero sign against every edge of the other triangle.
  for (genvar t = 0; t < 2; t++) begin : g_dir
    for (genvar k = 0; k < 3; k++) begin : g_vert
      localparam int B = t * 9 + k;
      assign vert_in[t][k] = (pos_v[B] & pos_v[B+3] & pos_v[B+6]) |
                             (neg_v[B] & neg_v[B+3] & neg_v[B+6]);
    end
    assign contain[t] = (|vert_in[t]) || !(|pos_v[t*9 +: 9]) || !(|neg_v[t*9 +: 9]);
  end

  // Proper crossing of second-triangle edge i and first-triangle edge j.
  for (genvar i = 0; i < 3; i++) begin : g_sedge
    for (genvar j = 0; j < 3; j++) begin : g_fedge
      localparam int Fa = i * 3 + j;
      localparam int Fb = i * 3 + (j + 1) % 3;
      localparam int Sa = 9 + j * 3 + i;
      localparam int Sb = 9 + j * 3 + (i + 1) % 3;
      assign cross_v[i*3+j] =
          ((pos_v[Fa] & neg_v[Fb]) | (neg_v[Fa] & pos_v[Fb])) &
          ((pos_v[Sa] & neg_v[Sb]) | (neg_v[Sa] & pos_v[Sb]));
    end
  end

  // Pick the first test that holds.
  always_comb begin
    if (contain[0]) begin
      code_d = DEC_FIRST;
    end else if (contain[1]) begin
      code_d = DEC_SECOND;
    end else if (|cross_v) begin
      code_d = DEC_CROSS;
    end else begin
      code_d = DEC_NONE;
    end
  end

  // Track stage occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result until the output transfer.
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= code_d;
    end
  end

  assign valid_o      = valid_q;
  assign decided_by_o = code_q;
  assign overlaps_o   = (code_q != DEC_NONE);

endmodule

`default_nettype wire
